@@ rtl/upd_pkg.sv @@
// ----------------------------------------------------------------------------
// upd_pkg
// Types, character codes and helper functions shared by the URL percent
// decoder modules.
// ----------------------------------------------------------------------------
package upd_pkg;

    // Characters with a meaning of their own
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_UP_A    = 8'h41;
    localparam logic [7:0] CHAR_UP_F    = 8'h46;
    localparam logic [7:0] CHAR_LO_A    = 8'h61;
    localparam logic [7:0] CHAR_LO_F    = 8'h66;
    localparam logic [3:0] HEX_TEN      = 4'hA;

    // Most result bytes one input byte can cause
    localparam int unsigned MAX_RESULTS = 3;

    // Escape phase
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } t_phase;

    // Decoded hex digit
    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_hex;

    // One queue entry: the result bytes of one input byte
    typedef struct packed {
        logic                        fin;
        logic [1:0]                  cnt;
        logic [MAX_RESULTS-1:0][7:0] bytes;
    } t_entry;

    // Result byte handed to the output register
    typedef struct packed {
        logic [7:0] char;
        logic       run_last;
        logic       string_end;
    } t_result;

    // Classify a character as a hex digit of either case
    function automatic t_hex hex_value(input logic [7:0] c);
        t_hex h;
        h.valid = 1'b1;
        h.value = 4'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            h.value = 4'(c - CHAR_ZERO);
        end else if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
            h.value = 4'(c - CHAR_UP_A) + HEX_TEN;
        end else if (c >= CHAR_LO_A && c <= CHAR_LO_F) begin
            h.value = 4'(c - CHAR_LO_A) + HEX_TEN;
        end else begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

endpackage

@@ rtl/upd_front.sv @@
// ----------------------------------------------------------------------------
// upd_front
// Accepts raw bytes, tracks the escape phase and turns each byte into a
// queue entry holding the one to three bytes it releases.
// ----------------------------------------------------------------------------
module upd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_char,
    input  logic            i_final,
    input  logic            i_q_ready,
    output logic            o_ready,
    output logic            o_push,
    output upd_pkg::t_entry o_entry
);

    upd_pkg::t_phase r_phase, n_phase;
    logic [7:0]      r_held, n_held;

    upd_pkg::t_hex   hx, hd;
    logic            accept;
    logic [7:0]      plain_char;
    logic            plain_open;
    logic            plain_path;
    logic [7:0]      pre0, pre1, tail0, tail1;
    logic [1:0]      pre_n, tail_n;
    upd_pkg::t_phase nxt_phase;
    logic            take_digit;

    assign o_ready = i_q_ready;
    assign accept  = i_valid && o_ready;

    // Plain handling of the current byte
    always_comb begin
        hx         = upd_pkg::hex_value(i_char);
        hd         = upd_pkg::hex_value(r_held);
        plain_open = (i_char == upd_pkg::CHAR_PERCENT);
        plain_char = (i_char == upd_pkg::CHAR_PLUS) ? upd_pkg::CHAR_SPACE : i_char;
    end

    // Build the prefix from the pending escape and the tail from this byte
    always_comb begin
        pre0       = upd_pkg::CHAR_PERCENT;
        pre1       = r_held;
        pre_n      = 2'd0;
        tail0      = plain_char;
        tail1      = i_char;
        tail_n     = 2'd0;
        plain_path = 1'b0;
        take_digit = 1'b0;
        nxt_phase  = upd_pkg::PH_IDLE;
        unique case (r_phase)
            upd_pkg::PH_PCT: begin
                if (hx.valid) begin
                    take_digit = 1'b1;
                    nxt_phase  = i_final ? upd_pkg::PH_IDLE : upd_pkg::PH_DIGIT;
                    // flush '%' and the digit at the end of the string
                    tail0      = upd_pkg::CHAR_PERCENT;
                    tail_n     = i_final ? 2'd2 : 2'd0;
                end else begin
                    pre_n      = 2'd1;
                    plain_path = 1'b1;
                end
            end
            upd_pkg::PH_DIGIT: begin
                if (hx.valid) begin
                    pre0  = {hd.value, hx.value};
                    pre_n = 2'd1;
                end else begin
                    pre_n      = 2'd2;
                    plain_path = 1'b1;
                end
            end
            default: begin
                plain_path = 1'b1;
            end
        endcase
        if (plain_path) begin
            if (plain_open) begin
                nxt_phase = i_final ? upd_pkg::PH_IDLE : upd_pkg::PH_PCT;
                tail0     = upd_pkg::CHAR_PERCENT;
                tail_n    = i_final ? 2'd1 : 2'd0;
            end else begin
                tail_n    = 2'd1;
            end
        end
    end

    // Pack prefix and tail into one entry
    always_comb begin
        o_entry.fin = i_final;
        o_entry.cnt = pre_n + tail_n;
        unique case (pre_n)
            2'd1: begin
                o_entry.bytes[0] = pre0;
                o_entry.bytes[1] = tail0;
                o_entry.bytes[2] = tail1;
            end
            2'd2: begin
                o_entry.bytes[0] = pre0;
                o_entry.bytes[1] = pre1;
                o_entry.bytes[2] = tail0;
            end
            default: begin
                o_entry.bytes[0] = tail0;
                o_entry.bytes[1] = tail1;
                o_entry.bytes[2] = 8'd0;
            end
        endcase
        o_push = accept && (o_entry.cnt != 2'd0);
    end

    // Next state
    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        if (accept) begin
            n_phase = nxt_phase;
            if (take_digit) begin
                n_held = i_char;
            end
        end
    end

    // Hold escape phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= upd_pkg::PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    // Hold the first digit of a pending escape
    always_ff @(posedge i_clk) begin
        r_held <= n_held;
    end

endmodule

@@ rtl/upd_queue.sv @@
// ----------------------------------------------------------------------------
// upd_queue
// Short first-in first-out queue of entries between the front and the back.
// ----------------------------------------------------------------------------
module upd_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  upd_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_ready,
    output logic            o_valid,
    output upd_pkg::t_entry o_head
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    upd_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count,  n_count;
    logic            do_push, do_pop;

    assign o_ready = (r_count != FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Advance pointers and count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count above depth");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count missed a push");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue empty with pointers apart");
`endif

endmodule

@@ rtl/upd_back.sv @@
// ----------------------------------------------------------------------------
// upd_back
// Unpacks queue entries one byte per cycle, while the output is ready, into
// the output register and marks the last byte of each entry and of each string.
// ----------------------------------------------------------------------------
module upd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  upd_pkg::t_entry  i_head,
    input  logic             i_out_ready,
    output logic             o_pop,
    output logic             o_valid,
    output upd_pkg::t_result o_result
);

    logic [1:0]       r_idx, n_idx;
    logic             r_valid, n_valid;
    upd_pkg::t_result r_result, n_result;
    logic             load;
    logic             is_last;

    assign load    = i_q_valid && (!r_valid || i_out_ready);
    assign is_last = (r_idx == i_head.cnt - 2'd1);
    assign o_pop   = load && is_last;
    assign o_valid = r_valid;
    assign o_result = r_result;

    // Pick the next byte of the head entry
    always_comb begin
        n_idx    = r_idx;
        n_valid  = r_valid;
        n_result = r_result;
        if (load) begin
            n_valid             = 1'b1;
            n_result.char       = i_head.bytes[r_idx];
            n_result.run_last   = is_last;
            n_result.string_end = is_last && i_head.fin;
            n_idx               = is_last ? 2'd0 : r_idx + 2'd1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    // Output word payload
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

`ifndef NO_ASSERTIONS
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx != 2'd3)
        else $error("byte index out of range");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_result.string_end) |-> r_result.run_last)
        else $error("string end not on last byte of entry");

    a_idx_within: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_q_valid && r_idx != 2'd0) |-> (r_idx < i_head.cnt))
        else $error("byte index beyond entry count");
`endif

endmodule

@@ rtl/url_percent_decoder.sv @@
// ----------------------------------------------------------------------------
// url_percent_decoder
// Form-urlencoded percent decoder: '%hh' becomes one byte, '+' a space,
// broken escapes pass through, pending escapes flush at the end of a string.
// ----------------------------------------------------------------------------
// The decoder takes one escaped byte per cycle and, while the output is
// ready, delivers decoded bytes one per cycle. An input byte releases zero
// to three output bytes, which leave the output one at a time, and a queue of
// QUEUE_DEPTH entries between the classifying front and the unpacking back
// absorbs such bursts, so input stalls only when it fills. A result passes
// through the queue and then the output register. On output, tuser flags
// the last byte caused by an input byte and tlast flags the last byte of
// the string.
module url_percent_decoder #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_char
    input  logic       i_s_axis_tlast,   // in_final
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_char
    output logic       o_m_axis_tuser,   // run_last
    output logic       o_m_axis_tlast    // string_end
);

    logic             q_push, q_pop, q_ready, q_valid;
    upd_pkg::t_entry  q_in, q_head;
    upd_pkg::t_result result;

    // Classify incoming words
    upd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .i_char    (i_s_axis_tdata),
        .i_final   (i_s_axis_tlast),
        .i_q_ready (q_ready),
        .o_ready   (o_s_axis_tready),
        .o_push    (q_push),
        .o_entry   (q_in)
    );

    // Decouple front and back
    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    // Emit output words
    upd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_head      (q_head),
        .i_out_ready (i_m_axis_tready),
        .o_pop       (q_pop),
        .o_valid     (o_m_axis_tvalid),
        .o_result    (result)
    );

    assign o_m_axis_tdata = result.char;
    assign o_m_axis_tuser = result.run_last;
    assign o_m_axis_tlast = result.string_end;

endmodule
